[rtl/bivariate_monomial_row_generator_unit_defines.svh]
// Assertion macros used by the bmrg_back module.
`ifndef BIVARIATE_MONOMIAL_ROW_GENERATOR_UNIT_DEFINES_SVH
`define BIVARIATE_MONOMIAL_ROW_GENERATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMRG_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bmrg: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BMRG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bmrg: next-cycle check failed");

`endif

[rtl/bmrg_pkg.sv]
package bmrg_pkg;

    localparam int MAX_DEGREE   = 9;
    localparam int FRAC_BITS    = 16;
    localparam int TABLE_DEPTH  = MAX_DEGREE + 1;
    localparam int DATA_W       = 32;
    localparam int EXP_W        = 4;
    localparam int CNT_W        = 6;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int SHIFT_W      = PROD_W - FRAC_BITS;
    localparam int QUEUE_SLOTS  = 2;
    localparam int SLOT_W       = $clog2(QUEUE_SLOTS);
    localparam int QCNT_W       = $clog2(QUEUE_SLOTS + 1);
    localparam int OFIFO_DEPTH  = 8;
    localparam int OFIFO_PTR_W  = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CNT_W  = $clog2(OFIFO_DEPTH + 1);
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = CNT_W;

    typedef logic signed [DATA_W-1:0] fix_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [EXP_W-1:0]         exp_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'd1;

    localparam exp_t DEGREE_RESET      = 4'd2;
    localparam cnt_t POINT_COUNT_RESET = 6'd6;

    localparam fix_t FIX_ONE = fix_t'(1) <<< FRAC_BITS;

    localparam logic signed [SHIFT_W-1:0] SAT_HI =
        {{(SHIFT_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [SHIFT_W-1:0] SAT_LO =
        {{(SHIFT_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_RND
    } front_state_t;

    typedef struct packed {
        logic we;
        exp_t addr;
        fix_t x_val;
        fix_t y_val;
    } tbl_wr_t;

    typedef struct packed {
        logic push;
        logic mismatch;
    } q_push_t;

    typedef struct packed {
        logic not_full;
        logic not_empty;
        logic mismatch;
    } q_status_t;

    // Round to nearest with ties upwards, then saturate to the data width.
    function automatic fix_t fx_round(input prod_t p);
        prod_t                     biased;
        logic signed [SHIFT_W-1:0] shifted;
        fix_t                      res;
        biased  = p + (prod_t'(1) <<< (FRAC_BITS - 1));
        shifted = biased[PROD_W-1:FRAC_BITS];
        if (shifted > SAT_HI) begin
            res = SAT_HI[DATA_W-1:0];
        end else if (shifted < SAT_LO) begin
            res = SAT_LO[DATA_W-1:0];
        end else begin
            res = shifted[DATA_W-1:0];
        end
        return res;
    endfunction

    // Number of monomials of total degree up to d.
    function automatic cnt_t tri_count(input exp_t d);
        logic [2*EXP_W+1:0] prod;
        prod = (2*EXP_W+2)'({1'b0, d} + 5'd1) * (2*EXP_W+2)'({1'b0, d} + 5'd2);
        return cnt_t'(prod >> 1);
    endfunction

endpackage

[rtl/bmrg_front.sv]
module bmrg_front import bmrg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fix_t                  s_x_coord,
    input  fix_t                  s_y_coord,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  q_status_t             q_status,
    output tbl_wr_t               tbl_wr,
    output q_push_t               q_push,
    output exp_t                  degree
);

    front_state_t state_reg, state_next;
    exp_t         degree_reg;
    cnt_t         point_count_reg;
    logic         buf_valid_reg, buf_valid_next;
    fix_t         buf_x_reg, buf_y_reg;
    logic         buf_mis_reg;
    fix_t         bx_reg, by_reg;
    fix_t         px_reg, px_next;
    fix_t         py_reg, py_next;
    exp_t         k_reg, k_next;
    prod_t        prodx_reg, prody_reg;
    logic         mismatch_now;
    logic         start;
    logic         build_done;

    assign degree  = degree_reg;
    assign s_ready = !buf_valid_reg;

    assign mismatch_now = (degree_reg > EXP_W'(MAX_DEGREE)) ||
                          (point_count_reg != tri_count(degree_reg));

    assign start      = (state_reg == F_IDLE) && buf_valid_reg && q_status.not_full;
    assign build_done = (k_reg == degree_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (start && !buf_mis_reg && (degree_reg != '0)) begin
                    state_next = F_MUL;
                end
            end
            F_MUL: begin
                state_next = F_RND;
            end
            F_RND: begin
                if (build_done) begin
                    state_next = F_IDLE;
                end else begin
                    state_next = F_MUL;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb begin
        tbl_wr         = '0;
        q_push         = '0;
        px_next        = px_reg;
        py_next        = py_reg;
        k_next         = k_reg;
        buf_valid_next = buf_valid_reg;
        if (s_valid && s_ready) begin
            buf_valid_next = 1'b1;
        end
        case (state_reg)
            F_IDLE: begin
                if (start) begin
                    buf_valid_next = 1'b0;
                    if (buf_mis_reg) begin
                        q_push.push     = 1'b1;
                        q_push.mismatch = 1'b1;
                    end else begin
                        tbl_wr.we    = 1'b1;
                        tbl_wr.addr  = '0;
                        tbl_wr.x_val = FIX_ONE;
                        tbl_wr.y_val = FIX_ONE;
                        px_next      = FIX_ONE;
                        py_next      = FIX_ONE;
                        k_next       = EXP_W'(1);
                        q_push.push  = (degree_reg == '0);
                    end
                end
            end
            F_RND: begin
                tbl_wr.we    = 1'b1;
                tbl_wr.addr  = k_reg;
                tbl_wr.x_val = fx_round(prodx_reg);
                tbl_wr.y_val = fx_round(prody_reg);
                px_next      = tbl_wr.x_val;
                py_next      = tbl_wr.y_val;
                k_next       = k_reg + EXP_W'(1);
                q_push.push  = build_done;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= F_IDLE;
            buf_valid_reg   <= 1'b0;
            degree_reg      <= DEGREE_RESET;
            point_count_reg <= POINT_COUNT_RESET;
        end else begin
            state_reg     <= state_next;
            buf_valid_reg <= buf_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DEGREE:      degree_reg      <= cfg_wdata[EXP_W-1:0];
                    CFG_POINT_COUNT: point_count_reg <= cfg_wdata[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            buf_x_reg   <= s_x_coord;
            buf_y_reg   <= s_y_coord;
            buf_mis_reg <= mismatch_now;
        end
        if (start) begin
            bx_reg <= buf_x_reg;
            by_reg <= buf_y_reg;
        end
        px_reg    <= px_next;
        py_reg    <= py_next;
        k_reg     <= k_next;
        prodx_reg <= px_reg * bx_reg;
        prody_reg <= py_reg * by_reg;
    end

endmodule

[rtl/bmrg_queue.sv]
module bmrg_queue import bmrg_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  tbl_wr_t   tbl_wr,
    input  q_push_t   q_push,
    input  logic      q_pop,
    input  exp_t      rd_ex,
    input  exp_t      rd_ey,
    output q_status_t q_status,
    output fix_t      rd_x,
    output fix_t      rd_y
);

    fix_t              x_mem [QUEUE_SLOTS][TABLE_DEPTH];
    fix_t              y_mem [QUEUE_SLOTS][TABLE_DEPTH];
    logic              mis_reg [QUEUE_SLOTS];
    logic [SLOT_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    fix_t              rd_x_reg, rd_y_reg;

    assign q_status.not_full  = (count_reg != QCNT_W'(QUEUE_SLOTS));
    assign q_status.not_empty = (count_reg != '0);
    assign q_status.mismatch  = mis_reg[rd_ptr_reg];
    assign rd_x = rd_x_reg;
    assign rd_y = rd_y_reg;

    always_comb begin
        count_next = count_reg;
        if (q_push.push && !q_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (q_pop && !q_push.push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (q_push.push) begin
                wr_ptr_reg <= wr_ptr_reg + SLOT_W'(1);
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push.push) begin
            mis_reg[wr_ptr_reg] <= q_push.mismatch;
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_wr.we) begin
            x_mem[wr_ptr_reg][tbl_wr.addr] <= tbl_wr.x_val;
            y_mem[wr_ptr_reg][tbl_wr.addr] <= tbl_wr.y_val;
        end
        rd_x_reg <= x_mem[rd_ptr_reg][rd_ex];
        rd_y_reg <= y_mem[rd_ptr_reg][rd_ey];
    end

endmodule

[rtl/bmrg_back.sv]
`include "bivariate_monomial_row_generator_unit_defines.svh"

module bmrg_back import bmrg_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  q_status_t q_status,
    input  exp_t      degree,
    output logic      q_pop,
    output exp_t      rd_ex,
    output exp_t      rd_ey,
    input  fix_t      rd_x,
    input  fix_t      rd_y,
    output logic      m_valid,
    input  logic      m_ready,
    output fix_t      m_monomial,
    output exp_t      m_x_power,
    output exp_t      m_y_power,
    output logic      m_last_in_row,
    output logic      m_count_mismatch
);

    typedef struct packed {
        exp_t x_pow;
        exp_t y_pow;
        logic last;
        logic mis;
    } meta_t;

    typedef struct packed {
        fix_t monomial;
        meta_t meta;
    } out_item_t;

    exp_t                   s_reg, ex_reg;
    exp_t                   ey;
    logic                   last;
    logic                   issue;
    logic                   v1_reg, v2_reg;
    meta_t                  meta_now, meta1_reg, meta2_reg;
    prod_t                  prod_reg;
    out_item_t              fifo_mem [OFIFO_DEPTH];
    out_item_t              fifo_head;
    logic [OFIFO_PTR_W-1:0] fifo_wr_reg, fifo_rd_reg;
    logic [OFIFO_CNT_W-1:0] fifo_cnt_reg;
    logic [OFIFO_CNT_W:0]   occupancy;
    logic                   fifo_pop;

    assign ey    = s_reg - ex_reg;
    assign last  = q_status.mismatch || ((s_reg == degree) && (ex_reg == '0));
    assign occupancy = {1'b0, fifo_cnt_reg} + (OFIFO_CNT_W+1)'(v1_reg)
                     + (OFIFO_CNT_W+1)'(v2_reg);
    assign issue = q_status.not_empty && (occupancy < (OFIFO_CNT_W+1)'(OFIFO_DEPTH));
    assign q_pop = issue && last;
    assign rd_ex = ex_reg;
    assign rd_ey = ey;

    assign meta_now.x_pow = ex_reg;
    assign meta_now.y_pow = ey;
    assign meta_now.last  = last;
    assign meta_now.mis   = q_status.mismatch;

    assign fifo_pop         = m_valid && m_ready;
    assign fifo_head        = fifo_mem[fifo_rd_reg];
    assign m_valid          = (fifo_cnt_reg != '0);
    assign m_monomial       = fifo_head.monomial;
    assign m_x_power        = fifo_head.meta.x_pow;
    assign m_y_power        = fifo_head.meta.y_pow;
    assign m_last_in_row    = fifo_head.meta.last;
    assign m_count_mismatch = fifo_head.meta.mis;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_reg        <= '0;
            ex_reg       <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            fifo_wr_reg  <= '0;
            fifo_rd_reg  <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (issue) begin
                if (last) begin
                    s_reg  <= '0;
                    ex_reg <= '0;
                end else if (ex_reg == '0) begin
                    s_reg  <= s_reg + EXP_W'(1);
                    ex_reg <= s_reg + EXP_W'(1);
                end else begin
                    ex_reg <= ex_reg - EXP_W'(1);
                end
            end
            if (v2_reg) begin
                fifo_wr_reg <= fifo_wr_reg + OFIFO_PTR_W'(1);
            end
            if (fifo_pop) begin
                fifo_rd_reg <= fifo_rd_reg + OFIFO_PTR_W'(1);
            end
            if (v2_reg && !fifo_pop) begin
                fifo_cnt_reg <= fifo_cnt_reg + OFIFO_CNT_W'(1);
            end else if (fifo_pop && !v2_reg) begin
                fifo_cnt_reg <= fifo_cnt_reg - OFIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        meta1_reg <= meta_now;
        meta2_reg <= meta1_reg;
        prod_reg  <= rd_x * rd_y;
        if (v2_reg) begin
            fifo_mem[fifo_wr_reg].monomial <= meta2_reg.mis ? '0 : fx_round(prod_reg);
            fifo_mem[fifo_wr_reg].meta     <= meta2_reg;
        end
    end

    `BMRG_ASSERT_IMPLY(a_fifo_bound, 1'b1, fifo_cnt_reg <= OFIFO_CNT_W'(OFIFO_DEPTH))
    `BMRG_ASSERT_IMPLY(a_error_item, m_valid && m_count_mismatch, m_last_in_row && (m_monomial == '0))
    `BMRG_ASSERT_IMPLY(a_exp_sum, m_valid && !m_count_mismatch, ({1'b0, m_x_power} + {1'b0, m_y_power}) <= {1'b0, degree})
    `BMRG_ASSERT_NEXT(a_walk_moves, issue && !last, (s_reg != '0) || (ex_reg != '0))

endmodule

[rtl/bivariate_monomial_row_generator_unit.sv]
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_x_coord, s_y_coord
// m_        out        m_valid/m_ready    m_monomial, m_x_power, m_y_power,
//                                         m_last_in_row, m_count_mismatch
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// At degree m a point gives T(m+1) = (m+1)(m+2)/2 results, one per cycle while the output
// queue has room, from the single monomial multiplier. The power build for the next point
// overlaps the current row; an error point gives one result.
// Reset is synchronous and active low; no clearing pass is needed after it.
// Either side may stall: a two-entry table queue and an eight-entry output queue absorb it.
module bivariate_monomial_row_generator_unit import bmrg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fix_t                  s_x_coord,
    input  fix_t                  s_y_coord,
    output logic                  m_valid,
    input  logic                  m_ready,
    output fix_t                  m_monomial,
    output exp_t                  m_x_power,
    output exp_t                  m_y_power,
    output logic                  m_last_in_row,
    output logic                  m_count_mismatch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    tbl_wr_t   tbl_wr;
    q_push_t   q_push;
    q_status_t q_status;
    exp_t      degree;
    logic      q_pop;
    exp_t      rd_ex, rd_ey;
    fix_t      rd_x, rd_y;

    bmrg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_x_coord (s_x_coord),
        .s_y_coord (s_y_coord),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_status  (q_status),
        .tbl_wr    (tbl_wr),
        .q_push    (q_push),
        .degree    (degree)
    );

    bmrg_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tbl_wr   (tbl_wr),
        .q_push   (q_push),
        .q_pop    (q_pop),
        .rd_ex    (rd_ex),
        .rd_ey    (rd_ey),
        .q_status (q_status),
        .rd_x     (rd_x),
        .rd_y     (rd_y)
    );

    bmrg_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_status         (q_status),
        .degree           (degree),
        .q_pop            (q_pop),
        .rd_ex            (rd_ex),
        .rd_ey            (rd_ey),
        .rd_x             (rd_x),
        .rd_y             (rd_y),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_monomial       (m_monomial),
        .m_x_power        (m_x_power),
        .m_y_power        (m_y_power),
        .m_last_in_row    (m_last_in_row),
        .m_count_mismatch (m_count_mismatch)
    );

endmodule
